// File: src/iss_pkg.sv
// shared types, constants and codes for the integer set store
package iss_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_TEST   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_PRESENT   = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the incoming transaction
    logic rd_en;      // issue one memory read at the walk pointer
    logic scan_mode;  // 0 value search, 1 min/max rescan
    logic apply;      // commit the request to the store
    logic publish;    // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_issue;   // walk pointer sits on the last valid entry
    logic count_zero;
    logic req_clear;
    logic rescan_due;   // successful remove that leaves entries behind
    logic out_busy;     // result register holds an untaken transaction
  } dp_sts_t;

endpackage

// File: src/integer_set_store_core.sv
// top level of the integer set store: controller plus datapath
// sequence: insert, test and remove walk the element memory for the value; a remove that
//   leaves entries behind walks it again for the min/max rescan; clear and empty-set requests skip the walk
// one transaction at a time: a new one is accepted only once the last result is published,
//   and a held result stalls that publish
// reset: synchronous active-low rst_n empties the set; memory contents are not cleared
module integer_set_store_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic signed [iss_pkg::DATA_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [iss_pkg::SIZE_W-1:0]        out_set_size,
  output logic                              out_is_empty,
  output logic signed [iss_pkg::DATA_W-1:0] out_min_value,
  output logic signed [iss_pkg::DATA_W-1:0] out_max_value
);
  import iss_pkg::*;

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accepts a transaction only when idle, so the result register
  // may still hold the previous result while the next one is worked on
  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: element memory, search walk, compaction by moving the last entry
  // into the hole, min/max tracking and the output register
  iss_dpath u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_set_size  (out_set_size),
    .out_is_empty  (out_is_empty),
    .out_min_value (out_min_value),
    .out_max_value (out_max_value)
  );

endmodule

// File: src/iss_dpath.sv
// datapath: element memory, count, search, min/max tracking and result register
module iss_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iss_pkg::dp_cmd_t              cmd,
  output iss_pkg::dp_sts_t              sts,
  input  logic [1:0]                    in_req_type,
  input  logic signed [iss_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic                          out_found,
  output logic [iss_pkg::SIZE_W-1:0]    out_set_size,
  output logic                          out_is_empty,
  output logic signed [iss_pkg::DATA_W-1:0] out_min_value,
  output logic signed [iss_pkg::DATA_W-1:0] out_max_value
);
  import iss_pkg::*;

  logic signed [DATA_W-1:0] mem [CAPACITY];

  req_t                     req_r;
  logic signed [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [ADDR_W-1:0]        idx_r;
  logic                     rd_vld_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  logic signed [DATA_W-1:0] rd_data_r;
  logic                     found_r, found_nxt;
  logic [ADDR_W-1:0]        pos_r, pos_nxt;
  logic signed [DATA_W-1:0] last_r, last_nxt;
  logic signed [DATA_W-1:0] min_r, min_nxt;
  logic signed [DATA_W-1:0] max_r, max_nxt;
  status_t                  status_r, status_nxt;

  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_is_last;

  logic                     out_valid_r;
  status_t                  out_status_r;
  logic                     out_found_r;
  logic [SIZE_W-1:0]        out_size_r;
  logic                     out_empty_r;
  logic signed [DATA_W-1:0] out_min_r;
  logic signed [DATA_W-1:0] out_max_r;

  assign rd_is_last = ((CNT_W'(rd_addr_r) + CNT_W'(1)) == count_r);

  assign sts.last_issue = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.count_zero = (count_r == '0);
  assign sts.req_clear  = (req_r == REQ_CLEAR);
  assign sts.rescan_due = (req_r == REQ_REMOVE) && found_r && (count_r > CNT_W'(1));
  assign sts.out_busy   = out_valid_r && !out_ready;

  // memory write: append on insert, move the last entry into the hole on remove
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_r;
    wr_data = last_r;
    if (cmd.apply) begin
      if (req_r == REQ_INSERT && !found_r && count_r < CNT_W'(CAPACITY)) begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(count_r);
        wr_data = val_r;
      end else if (req_r == REQ_REMOVE && found_r) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[idx_r];
    end
  end

  always_comb begin
    found_nxt  = found_r;
    pos_nxt    = pos_r;
    last_nxt   = last_r;
    min_nxt    = min_r;
    max_nxt    = max_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    if (cmd.load) begin
      found_nxt = 1'b0;
    end
    if (rd_vld_r && !cmd.scan_mode) begin
      if (rd_data_r == val_r) begin
        found_nxt = 1'b1;
        pos_nxt   = rd_addr_r;
      end
      if (rd_is_last) begin
        last_nxt = rd_data_r;
      end
    end
    if (rd_vld_r && cmd.scan_mode) begin
      if (rd_addr_r == '0) begin
        min_nxt = rd_data_r;
        max_nxt = rd_data_r;
      end else begin
        if (rd_data_r < min_r) min_nxt = rd_data_r;
        if (rd_data_r > max_r) max_nxt = rd_data_r;
      end
    end
    if (cmd.apply) begin
      status_nxt = ST_DONE;
      unique case (req_r)
        REQ_CLEAR: begin
          count_nxt = '0;
          found_nxt = 1'b0;
        end
        REQ_INSERT: begin
          if (found_r) begin
            status_nxt = ST_PRESENT;
          end else if (count_r >= CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
            if (count_r == '0) begin
              min_nxt = val_r;
              max_nxt = val_r;
            end else begin
              if (val_r < min_r) min_nxt = val_r;
              if (val_r > max_r) max_nxt = val_r;
            end
          end
        end
        REQ_REMOVE: begin
          if (!found_r) begin
            status_nxt = ST_NOT_FOUND;
          end else begin
            count_nxt = count_r - CNT_W'(1);
            // a single survivor is the one moved into the hole
            min_nxt = last_r;
            max_nxt = last_r;
          end
        end
        REQ_TEST: begin
          status_nxt = found_r ? ST_DONE : ST_NOT_FOUND;
        end
        default: status_nxt = ST_DONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_req_type);
      val_r <= in_value;
    end
    found_r   <= found_nxt;
    pos_r     <= pos_nxt;
    last_r    <= last_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    status_r  <= status_nxt;
    rd_addr_r <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      rd_vld_r <= cmd.rd_en;
      if (cmd.rd_en) begin
        idx_r <= idx_r + ADDR_W'(1);
      end else begin
        idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_size_r   <= SIZE_W'(count_r);
      out_empty_r  <= (count_r == '0);
      out_min_r    <= (count_r == '0) ? -DATA_W'(1) : min_r;
      out_max_r    <= (count_r == '0) ? -DATA_W'(1) : max_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_found     = out_found_r;
  assign out_set_size  = out_size_r;
  assign out_is_empty  = out_empty_r;
  assign out_min_value = out_min_r;
  assign out_max_value = out_max_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |-> (CNT_W'(idx_r) < count_r))
    else $error("memory read beyond valid entries");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid_r && !out_ready))
    else $error("result register overwritten while held");

  a_minmax_order: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (out_min_r <= out_max_r))
    else $error("published minimum above maximum");

endmodule

// File: src/iss_ctrl.sv
// controller: sequences load, search walk, commit, min/max rescan and publish
module iss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  iss_pkg::dp_sts_t sts,
  output iss_pkg::dp_cmd_t cmd
);
  import iss_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_START  = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_SDRAIN = 8'b0000_1000,
    S_APPLY  = 8'b0001_0000,
    S_MSCAN  = 8'b0010_0000,
    S_MDRAIN = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = (sts.req_clear || sts.count_zero) ? S_APPLY : S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (sts.last_issue) state_nxt = S_SDRAIN;
      end
      S_SDRAIN: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = sts.rescan_due ? S_MSCAN : S_DONE;
      end
      S_MSCAN: begin
        cmd.rd_en     = 1'b1;
        cmd.scan_mode = 1'b1;
        if (sts.last_issue) state_nxt = S_MDRAIN;
      end
      S_MDRAIN: begin
        cmd.scan_mode = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: test/integer_set_store_core_tb.sv
// testbench for integer_set_store_core: directed and random requests checked against a set predictor
module integer_set_store_core_tb;
  import iss_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int RESET_CYC   = 3;
  localparam int TOTAL_ITEMS = 950;
  localparam int SETTLE_CYC  = 3 * CAPACITY + 20;
  localparam int LIMIT_CYC   = 2_000_000;
  localparam int SHOWN_MAX   = 10;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct {
    status_t           status;
    logic              found;
    logic [SIZE_W-1:0] set_size;
    logic              is_empty;
    word_t             min_value;
    word_t             max_value;
  } set_result_t;

  // tracks the set contents and the results still owed by the block
  class set_scoreboard;
    word_t       members[$];
    set_result_t owed_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= SHOWN_MAX) $display("transaction %0d: %s", checked, msg);
    endfunction

    function void note_request(req_t req, word_t value);
      set_result_t r;
      int          pos;
      pos = -1;
      foreach (members[i]) begin
        if (pos < 0 && members[i] == value) pos = i;
      end
      r.status = ST_DONE;
      r.found  = 1'b0;
      if (req == REQ_CLEAR) begin
        members.delete();
      end else begin
        r.found = (pos >= 0);
        case (req)
          REQ_INSERT: begin
            if (pos >= 0) r.status = ST_PRESENT;
            else if (members.size() >= CAPACITY) r.status = ST_FULL;
            else members.push_back(value);
          end
          REQ_REMOVE: begin
            if (pos < 0) r.status = ST_NOT_FOUND;
            else members.delete(pos);
          end
          default: begin
            r.status = (pos >= 0) ? ST_DONE : ST_NOT_FOUND;
          end
        endcase
      end
      r.set_size  = SIZE_W'(members.size());
      r.is_empty  = (members.size() == 0);
      r.min_value = -1;
      r.max_value = -1;
      if (members.size() > 0) begin
        r.min_value = members[0];
        r.max_value = members[0];
        foreach (members[i]) begin
          if (members[i] < r.min_value) r.min_value = members[i];
          if (members[i] > r.max_value) r.max_value = members[i];
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(status_t st, logic fnd, logic [SIZE_W-1:0] sz, logic emp,
                               word_t lo, word_t hi);
      set_result_t e;
      checked++;
      if (owed_q.size() == 0) begin
        flag("result with no request outstanding");
        return;
      end
      e = owed_q.pop_front();
      if (st !== e.status)
        flag($sformatf("status expected %0d got %0d", e.status, st));
      if (fnd !== e.found)
        flag($sformatf("found expected %0b got %0b", e.found, fnd));
      if (sz !== e.set_size)
        flag($sformatf("set_size expected %0d got %0d", e.set_size, sz));
      if (emp !== e.is_empty)
        flag($sformatf("is_empty expected %0b got %0b", e.is_empty, emp));
      if (lo !== e.min_value)
        flag($sformatf("min_value expected %0d got %0d", e.min_value, lo));
      if (hi !== e.max_value)
        flag($sformatf("max_value expected %0d got %0d", e.max_value, hi));
    endfunction
  endclass

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [1:0]        in_req_type = REQ_CLEAR;
  word_t             in_value    = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic [1:0]        out_status;
  logic              out_found;
  logic [SIZE_W-1:0] out_set_size;
  logic              out_is_empty;
  word_t             out_min_value;
  word_t             out_max_value;

  set_scoreboard sb = new();
  int            send_idle = 17;
  int            recv_idle = 56;
  int            issued    = 0;
  int unsigned   cycle_count = 0;

  integer_set_store_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_found    (out_found),
    .out_set_size (out_set_size),
    .out_is_empty (out_is_empty),
    .out_min_value(out_min_value),
    .out_max_value(out_max_value)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYC) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: sample before this edge's updates, then pick next ready
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(status_t'(out_status), out_found, out_set_size, out_is_empty,
                        out_min_value, out_max_value);
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_request(input req_t req, input word_t value);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_value    <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req, value);
    issued++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
  endtask

  // nearly half members so that hits are common, some corner values, rest anything
  function automatic word_t pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 45 && sb.members.size() > 0)
      return sb.members[$urandom_range(sb.members.size() - 1)];
    if (k < 57) begin
      case ($urandom_range(4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    end
    return word_t'($urandom());
  endfunction

  initial begin
    int   phase;
    int   episode;
    int   len;
    int   grow;
    int   k;
    req_t op;

    phase   = 0;
    episode = 0;
    repeat (RESET_CYC) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners: empty set, extremes, duplicates, ordered removal
    send_request(REQ_CLEAR,  32'sh1234_5678);
    send_request(REQ_TEST,   -5);
    send_request(REQ_REMOVE, -5);
    send_request(REQ_INSERT, 32'sh7fff_ffff);
    send_request(REQ_INSERT, 32'sh8000_0000);
    send_request(REQ_INSERT, 0);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, -1);
    send_request(REQ_TEST,   -1);
    send_request(REQ_TEST,   12345);
    send_request(REQ_REMOVE, 0);
    send_request(REQ_REMOVE, 0);
    send_request(REQ_INSERT, 32'sh5555_5555);
    send_request(REQ_INSERT, 32'shAAAA_AAAA);
    send_request(REQ_REMOVE, 32'sh7fff_ffff);
    send_request(REQ_REMOVE, 32'shAAAA_AAAA);
    send_request(REQ_TEST,   32'sh8000_0000);
    send_request(REQ_CLEAR,  -1);
    send_request(REQ_TEST,   32'sh5555_5555);
    send_request(REQ_INSERT, 1);
    send_request(REQ_REMOVE, 1);

    while (issued < TOTAL_ITEMS) begin
      if (phase < 2 && issued * 3 >= TOTAL_ITEMS * (phase + 1)) begin
        // sender holds off until the block has drained; idle rates then swap, later both go to zero
        wait_for_results();
        @(posedge clk);
        phase++;
        send_idle = (phase == 1) ? 56 : 0;
        recv_idle = (phase == 1) ? 17 : 0;
      end
      if (episode == 0 || ($urandom_range(7) == 0 && issued + 180 <= TOTAL_ITEMS)) begin
        // fill to capacity, push against full, then thin out and refill
        send_request(REQ_CLEAR, word_t'($urandom()));
        while (sb.members.size() < CAPACITY) begin
          if ($urandom_range(9) == 0) send_request(REQ_TEST, pick_value());
          else send_request(REQ_INSERT, word_t'($urandom()));
        end
        send_request(REQ_INSERT, word_t'($urandom()));
        send_request(REQ_INSERT, sb.members[$urandom_range(CAPACITY - 1)]);
        send_request(REQ_TEST, pick_value());
        repeat (20) send_request(REQ_REMOVE, pick_value());
        repeat (10) send_request(REQ_INSERT, pick_value());
      end else begin
        len  = $urandom_range(60, 20);
        grow = $urandom_range(1);
        repeat (len) begin
          k = $urandom_range(99);
          if (k < 2) op = REQ_CLEAR;
          else if (k < (grow ? 60 : 30)) op = REQ_INSERT;
          else if (k < 78) op = REQ_REMOVE;
          else op = REQ_TEST;
          send_request(op, pick_value());
        end
      end
      episode++;
    end

    wait_for_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/iss_pkg.sv
src/iss_dpath.sv
src/iss_ctrl.sv
src/integer_set_store_core.sv
test/integer_set_store_core_tb.sv
